FILE: rtl/ads_pkg.sv
// shared types, constants and table helpers for the anisotropic diffusion block
// no dependencies
`timescale 1ns / 1ps

package ads_pkg;

    // default sizing
    localparam int MAX_WIDTH_DEF      = 1024;
    localparam int MAX_HEIGHT_DEF     = 1024;
    localparam int EXP_TABLE_SIZE_DEF = 256;

    // configuration port
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_K_SQ     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_GAIN  = 4'd3;

    localparam int SIZE_REG_W = 11;
    localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 11'd1024;
    localparam logic [15:0] INV_K_SQ_RESET    = 16'd1;
    localparam logic [15:0] LAMBDA_GAIN_RESET = 16'd1638;

    // neighbour slots in the datapath
    localparam logic [2:0] NB_CTR   = 3'd0;
    localparam logic [2:0] NB_NORTH = 3'd1;
    localparam logic [2:0] NB_SOUTH = 3'd2;
    localparam logic [2:0] NB_EAST  = 3'd3;
    localparam logic [2:0] NB_WEST  = 3'd4;

    // table index = floor(x * size / 8), x in Q.32
    localparam int EXP_SHIFT = 35;

    localparam logic [63:0] ONE_Q32     = 64'd4294967296;
    localparam logic [63:0] EXP_NEG1_Q32 = 64'd1580030169;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PICK,
        S_READ,
        S_LOAD,
        S_SQ,
        S_SCALE,
        S_LOOK,
        S_ACC,
        S_MUL,
        S_OUT,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic       mem_we;
        logic       mem_re;
        logic       load_nb;
        logic [2:0] nb_sel;
        logic       nb_ok;
        logic       sq;
        logic       scale;
        logic       look;
        logic       acc;
        logic       acc_clr;
        logic       mul;
        logic       fin;
        logic       run_last;
        logic       frame_end;
    } t_cmd;

    // ring of three row slots
    function automatic logic [1:0] slot_inc(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [1:0] slot_dec(input logic [1:0] s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    // exp(-t) for t in Q32.32, as Q1.16 rounded; elaboration only
    function automatic logic [16:0] exp_q16(input logic [63:0] t);
        logic [63:0]        f;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [64:0] sum;
        logic [31:0]        whole;
        whole = t[63:32];
        f     = {32'd0, t[31:0]};
        term  = ONE_Q32;
        sum   = $signed({1'b0, ONE_Q32});
        // taylor series of the fraction
        for (int k = 1; k <= 16; k++) begin
            term = ((term * f) >> 32) / 64'(k);
            if (k[0]) sum = sum - $signed({1'b0, term});
            else      sum = sum + $signed({1'b0, term});
        end
        if (sum < 0) sum = '0;
        v = sum[63:0];
        // whole part by powers of 1/e
        for (int k = 0; k < 8; k++) begin
            if (32'(k) < whole) v = (v * EXP_NEG1_Q32) >> 32;
        end
        return 17'((v + 64'd32768) >> 16);
    endfunction

endpackage

FILE: rtl/ads_ctrl.sv
// controller: raster position, result scheduling and the per-result sequence
// depends on ads_pkg
`timescale 1ns / 1ps

module ads_ctrl #(
    parameter int MAX_WIDTH  = ads_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ads_pkg::MAX_HEIGHT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    output logic                      o_valid,
    input  logic                      i_ready,
    input  logic [ads_pkg::SIZE_REG_W-1:0] i_frame_width,
    input  logic [ads_pkg::SIZE_REG_W-1:0] i_frame_height,
    output ads_pkg::t_cmd             o_cmd,
    output logic [$clog2(3*MAX_WIDTH)-1:0] o_wr_addr,
    output logic [$clog2(3*MAX_WIDTH)-1:0] o_rd_addr
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WEW = $clog2(MAX_WIDTH + 1);
    localparam int HEW = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = $clog2(3*MAX_WIDTH);

    ads_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [1:0]    r_slot;
    logic [RW-1:0] r_ir;
    logic [CW-1:0] r_ic;
    logic [1:0]    r_is;
    logic [2:0]    r_jobs;
    logic [1:0]    r_js;
    logic [CW-1:0] r_jc;
    logic [4:0]    r_ok;
    logic          r_jlast;
    logic          r_jend;
    logic [2:0]    r_k;

    logic [WEW-1:0] w_w;
    logic [HEW-1:0] w_h;
    logic           w_restart;
    logic [CW-1:0]  w_c;
    logic [RW-1:0]  w_r;
    logic [1:0]     w_s;
    logic           w_last_row;
    logic           w_take;

    // effective frame size
    always_comb begin
        if (i_frame_width == '0) w_w = WEW'(1);
        else if (32'(i_frame_width) > 32'(MAX_WIDTH)) w_w = WEW'(MAX_WIDTH);
        else w_w = WEW'(i_frame_width);
        if (i_frame_height == '0) w_h = HEW'(1);
        else if (32'(i_frame_height) > 32'(MAX_HEIGHT)) w_h = HEW'(MAX_HEIGHT);
        else w_h = HEW'(i_frame_height);
    end

    // position of the arriving item, restarting when out of range
    always_comb begin
        w_restart  = (32'(r_col) >= 32'(w_w)) || (32'(r_row) >= 32'(w_h));
        w_c        = w_restart ? '0 : r_col;
        w_r        = w_restart ? '0 : r_row;
        w_s        = w_restart ? 2'd0 : r_slot;
        w_last_row = (32'(w_r) + 32'd1 == 32'(w_h));
        w_take     = i_valid && (r_state == ads_pkg::S_IDLE);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ads_pkg::S_IDLE:  if (i_valid) n_state = ads_pkg::S_PICK;
            ads_pkg::S_PICK:  n_state = (r_jobs == 3'd0) ? ads_pkg::S_IDLE : ads_pkg::S_READ;
            ads_pkg::S_READ:  n_state = ads_pkg::S_LOAD;
            ads_pkg::S_LOAD:  n_state = (r_k == ads_pkg::NB_WEST) ? ads_pkg::S_SQ
                                                                 : ads_pkg::S_READ;
            ads_pkg::S_SQ:    n_state = ads_pkg::S_SCALE;
            ads_pkg::S_SCALE: n_state = ads_pkg::S_LOOK;
            ads_pkg::S_LOOK:  n_state = ads_pkg::S_ACC;
            ads_pkg::S_ACC:   n_state = (r_k == ads_pkg::NB_WEST) ? ads_pkg::S_MUL
                                                                 : ads_pkg::S_SQ;
            ads_pkg::S_MUL:   n_state = ads_pkg::S_OUT;
            ads_pkg::S_OUT:   n_state = ads_pkg::S_HOLD;
            ads_pkg::S_HOLD:  if (i_ready) n_state = ads_pkg::S_PICK;
            default:          n_state = ads_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.nb_sel    = r_k;
        o_cmd.nb_ok     = r_ok[r_k];
        o_cmd.run_last  = r_jlast;
        o_cmd.frame_end = r_jend;
        o_ready         = (r_state == ads_pkg::S_IDLE);
        o_valid         = (r_state == ads_pkg::S_HOLD);
        o_wr_addr       = AW'(32'(w_s) * 32'(MAX_WIDTH) + 32'(w_c));
        case (r_k)
            ads_pkg::NB_NORTH:
                o_rd_addr = AW'(32'(ads_pkg::slot_dec(r_js)) * 32'(MAX_WIDTH) + 32'(r_jc));
            ads_pkg::NB_SOUTH:
                o_rd_addr = AW'(32'(ads_pkg::slot_inc(r_js)) * 32'(MAX_WIDTH) + 32'(r_jc));
            ads_pkg::NB_EAST:
                o_rd_addr = AW'(32'(r_js) * 32'(MAX_WIDTH) + 32'(r_jc) + 32'd1);
            ads_pkg::NB_WEST:
                o_rd_addr = AW'(32'(r_js) * 32'(MAX_WIDTH) + 32'(r_jc) - 32'd1);
            default:
                o_rd_addr = AW'(32'(r_js) * 32'(MAX_WIDTH) + 32'(r_jc));
        endcase
        case (r_state)
            ads_pkg::S_IDLE:  o_cmd.mem_we  = i_valid;
            ads_pkg::S_PICK:  o_cmd.acc_clr = 1'b1;
            ads_pkg::S_READ:  o_cmd.mem_re  = 1'b1;
            ads_pkg::S_LOAD:  o_cmd.load_nb = 1'b1;
            ads_pkg::S_SQ:    o_cmd.sq      = 1'b1;
            ads_pkg::S_SCALE: o_cmd.scale   = 1'b1;
            ads_pkg::S_LOOK:  o_cmd.look    = 1'b1;
            ads_pkg::S_ACC:   o_cmd.acc     = 1'b1;
            ads_pkg::S_MUL:   o_cmd.mul     = 1'b1;
            ads_pkg::S_OUT:   o_cmd.fin     = 1'b1;
            default:          o_cmd.mem_we  = 1'b0;
        endcase
    end

    // state and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ads_pkg::S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_slot  <= 2'd0;
            r_jobs  <= 3'd0;
            r_k     <= ads_pkg::NB_CTR;
        end else begin
            r_state <= n_state;
            if (w_take) begin
                r_ir   <= w_r;
                r_ic   <= w_c;
                r_is   <= w_s;
                r_jobs <= {w_last_row && (32'(w_c) + 32'd1 == 32'(w_w)),
                           w_last_row && (w_c != '0),
                           w_r != '0};
                if (32'(w_c) + 32'd1 >= 32'(w_w)) begin
                    r_col <= '0;
                    if (32'(w_r) + 32'd1 >= 32'(w_h)) begin
                        r_row  <= '0;
                        r_slot <= 2'd0;
                    end else begin
                        r_row  <= w_r + RW'(1);
                        r_slot <= ads_pkg::slot_inc(w_s);
                    end
                end else begin
                    r_col <= w_c + CW'(1);
                    r_row <= w_r;
                    r_slot <= w_s;
                end
            end
            case (r_state)
                ads_pkg::S_PICK: r_k <= ads_pkg::NB_CTR;
                ads_pkg::S_LOAD: r_k <= (r_k == ads_pkg::NB_WEST) ? ads_pkg::NB_NORTH
                                                                  : r_k + 3'd1;
                ads_pkg::S_ACC:  r_k <= r_k + 3'd1;
                default:         r_k <= r_k;
            endcase
            // pick the next pending result, lowest first
            if (r_state == ads_pkg::S_PICK) begin
                if (r_jobs[0]) r_jobs[0] <= 1'b0;
                else if (r_jobs[1]) r_jobs[1] <= 1'b0;
                else r_jobs[2] <= 1'b0;
            end
        end
    end

    // job position and neighbour existence
    always_ff @(posedge i_clk) begin
        if (r_state == ads_pkg::S_PICK) begin
            logic [RW-1:0] v_jr;
            logic [CW-1:0] v_jc;
            if (r_jobs[0]) begin
                v_jr    = r_ir - RW'(1);
                v_jc    = r_ic;
                r_js    <= ads_pkg::slot_dec(r_is);
                r_jlast <= (r_jobs[2:1] == 2'd0);
                r_jend  <= 1'b0;
            end else if (r_jobs[1]) begin
                v_jr    = r_ir;
                v_jc    = r_ic - CW'(1);
                r_js    <= r_is;
                r_jlast <= !r_jobs[2];
                r_jend  <= 1'b0;
            end else begin
                v_jr    = r_ir;
                v_jc    = r_ic;
                r_js    <= r_is;
                r_jlast <= 1'b1;
                r_jend  <= 1'b1;
            end
            r_jc <= v_jc;
            r_ok <= {v_jc != '0,
                     32'(v_jc) + 32'd1 < 32'(w_w),
                     32'(v_jr) + 32'd1 < 32'(w_h),
                     v_jr != '0,
                     1'b1};
        end
    end

endmodule

FILE: rtl/ads_datapath.sv
// datapath: three-row line store, shared flux unit, accumulate and update
// depends on ads_pkg
`timescale 1ns / 1ps

module ads_datapath #(
    parameter int MAX_WIDTH      = ads_pkg::MAX_WIDTH_DEF,
    parameter int EXP_TABLE_SIZE = ads_pkg::EXP_TABLE_SIZE_DEF
) (
    input  logic                           i_clk,
    input  ads_pkg::t_cmd                  i_cmd,
    input  logic [$clog2(3*MAX_WIDTH)-1:0] i_wr_addr,
    input  logic [$clog2(3*MAX_WIDTH)-1:0] i_rd_addr,
    input  logic [15:0]                    i_pixel_in,
    input  logic [15:0]                    i_inv_k_sq,
    input  logic [15:0]                    i_lambda_gain,
    output logic [15:0]                    o_pixel_out,
    output logic                           o_run_last,
    output logic                           o_frame_end
);

    localparam int DEPTH = 3*MAX_WIDTH;
    localparam int IDX_W = $clog2(EXP_TABLE_SIZE);
    localparam int SZ_W  = $clog2(EXP_TABLE_SIZE + 1);
    localparam int X_W   = 48;
    localparam int SC_W  = X_W + SZ_W;
    localparam int ACC_W = 36;
    localparam int PR_W  = 54;

    logic [15:0] mem [DEPTH];
    logic [15:0] r_rd_data;
    logic [15:0] r_nb [5];
    logic signed [16:0] r_d;
    logic [31:0]        r_sq;
    logic [X_W-1:0]     r_x;
    logic [16:0]        r_wt;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [PR_W-1:0]  r_prod;

    logic [16:0]        w_tab [EXP_TABLE_SIZE];
    logic signed [16:0] w_d;
    logic [15:0]        w_mag;
    logic [SC_W-1:0]    w_scaled;
    logic [SC_W-1:0]    w_pos;
    logic signed [34:0] w_flux;
    logic signed [PR_W-1:0] w_rnd;
    logic signed [22:0] w_v;

    // exp weight table, built at elaboration
    for (genvar g = 0; g < EXP_TABLE_SIZE; g++) begin : g_tab
        localparam logic [63:0] T = ((64'(g) * 64'd8) << 32) / 64'(EXP_TABLE_SIZE);
        assign w_tab[g] = ads_pkg::exp_q16(T);
    end

    // line store, one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) mem[i_wr_addr] <= i_pixel_in;
        if (i_cmd.mem_re) r_rd_data <= mem[i_rd_addr];
    end

    // flux unit arithmetic
    always_comb begin
        w_d = i_cmd.nb_ok ? ($signed({1'b0, r_nb[i_cmd.nb_sel]}) - $signed({1'b0, r_nb[0]}))
                          : 17'sd0;
        w_mag    = w_d[16] ? 16'(-w_d) : w_d[15:0];
        w_scaled = SC_W'(r_x) * SC_W'(EXP_TABLE_SIZE);
        w_pos    = w_scaled >> ads_pkg::EXP_SHIFT;
        w_flux   = r_d * $signed({1'b0, r_wt});
        w_rnd    = r_prod + PR_W'(64'd2147483648);
        w_v      = $signed({7'd0, r_nb[0]}) + 23'($signed(w_rnd[PR_W-1:32]));
    end

    // neighbourhood capture, flux stages and update
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_nb) r_nb[i_cmd.nb_sel] <= r_rd_data;
        if (i_cmd.sq) begin
            r_d  <= w_d;
            r_sq <= w_mag * w_mag;
        end
        if (i_cmd.scale) r_x <= r_sq * X_W'(i_inv_k_sq);
        if (i_cmd.look) begin
            if (w_pos < SC_W'(EXP_TABLE_SIZE)) r_wt <= w_tab[w_pos[IDX_W-1:0]];
            else r_wt <= '0;
        end
        if (i_cmd.acc_clr) r_acc <= '0;
        else if (i_cmd.acc) r_acc <= r_acc + ACC_W'(w_flux);
        if (i_cmd.mul) r_prod <= r_acc * $signed({1'b0, i_lambda_gain});
        if (i_cmd.fin) begin
            if (w_v < 0) o_pixel_out <= 16'd0;
            else if (w_v > 23'sd65535) o_pixel_out <= 16'hFFFF;
            else o_pixel_out <= w_v[15:0];
            o_run_last  <= i_cmd.run_last;
            o_frame_end <= i_cmd.frame_end;
        end
    end

endmodule

FILE: rtl/anisotropic_diffusion_step.sv
// top level: configuration registers, controller and datapath of one diffusion pass
// depends on ads_pkg, ads_ctrl, ads_datapath
//
// channel  direction  handshake                  payload
// input    in         i_valid / o_ready          i_pixel_in
// result   out        o_valid / i_ready          o_pixel_out, o_run_last, o_frame_end
// config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one item at a time: an item is accepted only in idle, its results (none to three)
// are produced one after another, and the block then returns to idle
// the single read port of the line store (5 reads) and the shared flux unit
// (4 passes of 4 stages) set the work per result
// a result waits in its output register while i_ready is low; o_ready stays low
// synchronous active-low reset clears position and control; the store needs no clearing
`timescale 1ns / 1ps

module anisotropic_diffusion_step #(
    parameter int MAX_WIDTH      = ads_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT     = ads_pkg::MAX_HEIGHT_DEF,
    parameter int EXP_TABLE_SIZE = ads_pkg::EXP_TABLE_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [15:0]                    i_pixel_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [15:0]                    o_pixel_out,
    output logic                           o_run_last,
    output logic                           o_frame_end,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ads_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ads_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(3*MAX_WIDTH);

    logic [ads_pkg::SIZE_REG_W-1:0] r_frame_width;
    logic [ads_pkg::SIZE_REG_W-1:0] r_frame_height;
    logic [15:0] r_inv_k_sq;
    logic [15:0] r_lambda_gain;

    ads_pkg::t_cmd w_cmd;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= ads_pkg::SIZE_RESET;
            r_frame_height <= ads_pkg::SIZE_RESET;
            r_inv_k_sq     <= ads_pkg::INV_K_SQ_RESET;
            r_lambda_gain  <= ads_pkg::LAMBDA_GAIN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ads_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[10:0];
                ads_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[10:0];
                ads_pkg::CFG_INV_K_SQ:     r_inv_k_sq     <= i_cfg_data;
                ads_pkg::CFG_LAMBDA_GAIN:  r_lambda_gain  <= i_cfg_data;
                default:                   r_inv_k_sq     <= r_inv_k_sq;
            endcase
        end
    end

    ads_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_cmd          (w_cmd),
        .o_wr_addr      (w_wr_addr),
        .o_rd_addr      (w_rd_addr)
    );

    ads_datapath #(
        .MAX_WIDTH      (MAX_WIDTH),
        .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .i_wr_addr     (w_wr_addr),
        .i_rd_addr     (w_rd_addr),
        .i_pixel_in    (i_pixel_in),
        .i_inv_k_sq    (r_inv_k_sq),
        .i_lambda_gain (r_lambda_gain),
        .o_pixel_out   (o_pixel_out),
        .o_run_last    (o_run_last),
        .o_frame_end   (o_frame_end)
    );

    // input and result sides are never open together
    a_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while a result is pending");

    // the frame's final pixel closes its item
    a_end_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> o_run_last)
        else $error("frame end without run last");

    // after the last result of an item the block is ready again
    a_back_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_run_last) |-> ##2 o_ready)
        else $error("not ready after last result");

    // a result never shows up in the cycle after an item is taken
    a_no_early : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_valid)
        else $error("result too early");

endmodule
